### src/u8enc_pkg.sv
package u8enc_pkg;

    // Input mode codes
    localparam logic [1:0] MODE_UTF16 = 2'd0;
    localparam logic [1:0] MODE_UTF32 = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Default depth of the queue between front and back
    localparam int FIFO_DEPTH = 4;

    // Status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // One encoded item: up to four bytes, first byte in slot 0
    typedef struct packed {
        logic            err;
        logic [2:0]      count;
        logic [3:0][7:0] bytes;
    } t_entry;

endpackage

### src/utf16_utf32_to_utf8_encoder_top.sv
// UTF-16 / UTF-32 to UTF-8 encoder.
// Input channel: queue style. A transaction (i_mode, i_code_value) is taken
// at a clock edge with push high and full low. Mode 0 is a UTF-16 code unit,
// mode 1 a UTF-32 code point, mode 2 clears a pending high surrogate.
// Output channel: queue style. While empty is low the oldest byte sits on
// o_out_byte/o_byte_count/o_is_last/o_status; pop high takes it.
// Each code point gives 1 to 4 byte transactions, the last one flagged; bad
// input gives one error transaction (status 1, byte and count zero).
// Throughput: one input transaction per cycle while the encoded-item queue
// has room; the output side moves one byte per cycle while pop is high, so
// a 4-byte character holds the byte serializer until its four bytes are
// taken. The first byte is written to the queue, then to the output register.
// When the receiver stalls, the queue (DEPTH entries) fills and then full
// rises; the front keeps accepting items that give no output only while
// full is low. Reset empties the queue and clears the pending surrogate.
module utf16_utf32_to_utf8_encoder_top #(
    parameter int DEPTH = u8enc_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_code_value,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_byte_count,
    output logic        o_is_last,
    output logic        o_status
);

    logic              w_accept;
    logic              w_wr;
    u8enc_pkg::t_entry w_wentry;
    u8enc_pkg::t_entry w_rentry;
    logic              w_rd;
    logic              w_q_empty;
    logic              w_pending;

    assign w_accept = push && !full;

    // Front: surrogate pairing and encoding
    u8enc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_mode       (i_mode),
        .i_code_value (i_code_value),
        .o_wr         (w_wr),
        .o_entry      (w_wentry),
        .o_pending    (w_pending)
    );

    // Queue of encoded items
    u8enc_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_wdata (w_wentry),
        .i_rd    (w_rd),
        .o_rdata (w_rentry),
        .o_full  (full),
        .o_empty (w_q_empty)
    );

    // Back: byte serializer with output register
    u8enc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (w_q_empty),
        .i_q_entry    (w_rentry),
        .o_q_rd       (w_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_byte_count (o_byte_count),
        .o_is_last    (o_is_last),
        .o_status     (o_status)
    );

    // Error transactions carry no byte and always close the sequence
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status) |-> (o_is_last && o_byte_count == 3'd0 && o_out_byte == 8'd0))
        else $error("error transaction malformed");

    // Valid bytes always carry a sequence length
    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_status) |-> (o_byte_count != 3'd0 && o_byte_count <= 3'd4))
        else $error("valid byte without sequence length");

    // A clear command drops any pending high surrogate
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_mode == u8enc_pkg::MODE_CLEAR) |=> !w_pending)
        else $error("pending surrogate survived clear");

    // Output side is empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !w_pending))
        else $error("state not cleared by reset");

endmodule

### src/u8enc_front.sv
module u8enc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_mode,
    input  logic [31:0]         i_code_value,
    output logic                o_wr,
    output u8enc_pkg::t_entry   o_entry,
    output logic                o_pending
);

    logic        r_pend;
    logic        n_pend;
    logic [9:0]  r_hi;
    logic [9:0]  n_hi;
    logic [15:0] w_unit;
    logic        w_is_high;
    logic        w_is_low;
    logic        w_force_err;
    logic [31:0] w_cp;

    // Encode one code point into UTF-8 bytes, or an error entry
    function automatic u8enc_pkg::t_entry encode(input logic [31:0] cp);
        u8enc_pkg::t_entry e;
        e.err   = 1'b0;
        e.count = 3'd0;
        e.bytes = '0;
        if (cp <= 32'h7F) begin
            e.bytes[0] = cp[7:0];
            e.count    = 3'd1;
        end else if (cp <= 32'h7FF) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.count    = 3'd2;
        end else if (cp >= 32'hD800 && cp <= 32'hDFFF) begin
            e.err = 1'b1;
        end else if (cp <= 32'hFFFF) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.count    = 3'd3;
        end else if (cp <= 32'h10FFFF) begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.count    = 3'd4;
        end else begin
            e.err = 1'b1;
        end
        return e;
    endfunction

    // Surrogate classification of the low 16 bits
    assign w_unit    = i_code_value[15:0];
    assign w_is_high = (w_unit inside {[16'hD800:16'hDBFF]});
    assign w_is_low  = (w_unit inside {[16'hDC00:16'hDFFF]});

    // Pending-surrogate handling and queue write decision
    always_comb begin
        n_pend      = r_pend;
        n_hi        = r_hi;
        o_wr        = 1'b0;
        w_force_err = 1'b0;
        w_cp        = i_code_value;
        if (i_accept) begin
            case (i_mode)
                u8enc_pkg::MODE_UTF16: begin
                    if (r_pend) begin
                        n_pend = 1'b0;
                        n_hi   = '0;
                        o_wr   = 1'b1;
                        if (!w_is_low) begin
                            w_force_err = 1'b1;
                        end
                        w_cp = {12'd0, r_hi, w_unit[9:0]} + 32'h10000;
                    end else if (w_is_high) begin
                        n_pend = 1'b1;
                        n_hi   = w_unit[9:0];
                    end else begin
                        o_wr = 1'b1;
                        w_cp = {16'd0, w_unit};
                    end
                end
                u8enc_pkg::MODE_UTF32: begin
                    n_pend = 1'b0;
                    n_hi   = '0;
                    o_wr   = 1'b1;
                end
                u8enc_pkg::MODE_CLEAR: begin
                    n_pend = 1'b0;
                    n_hi   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Entry pushed into the queue
    always_comb begin
        o_entry = encode(w_cp);
        if (w_force_err) begin
            o_entry.err   = 1'b1;
            o_entry.count = 3'd0;
            o_entry.bytes = '0;
        end
    end

    // Pending state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_hi   <= '0;
        end else begin
            r_pend <= n_pend;
            r_hi   <= n_hi;
        end
    end

    assign o_pending = r_pend;

endmodule

### src/u8enc_fifo.sv
module u8enc_fifo #(
    parameter int DEPTH = u8enc_pkg::FIFO_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  u8enc_pkg::t_entry   i_wdata,
    input  logic                i_rd,
    output u8enc_pkg::t_entry   o_rdata,
    output logic                o_full,
    output logic                o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u8enc_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]     r_wptr;
    logic [AW-1:0]     r_rptr;
    logic [CW-1:0]     r_cnt;
    logic              w_do_wr;
    logic              w_do_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_do_wr = i_wr && !o_full;
    assign w_do_rd = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_do_wr) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_do_rd) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_do_wr && !w_do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_rd && !w_do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### src/u8enc_back.sv
module u8enc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  u8enc_pkg::t_entry   i_q_entry,
    output logic                o_q_rd,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [7:0]          o_out_byte,
    output logic [2:0]          o_byte_count,
    output logic                o_is_last,
    output logic                o_status
);

    logic       r_val;
    logic [1:0] r_idx;
    logic [7:0] r_byte;
    logic [2:0] r_count;
    logic       r_last;
    logic       r_status;
    logic       w_load;
    logic       w_last;

    // Load the next byte when the output register is free or being taken
    assign w_load = !i_q_empty && (!r_val || i_pop);
    assign w_last = i_q_entry.err || ({1'b0, r_idx} == (i_q_entry.count - 3'd1));
    assign o_q_rd = w_load && w_last;

    // Byte index within the head entry and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= 1'b0;
            r_idx <= '0;
        end else begin
            if (w_load) begin
                r_val <= 1'b1;
                r_idx <= w_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_val <= 1'b0;
            end
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte   <= i_q_entry.bytes[r_idx];
            r_count  <= i_q_entry.count;
            r_last   <= w_last;
            r_status <= i_q_entry.err ? u8enc_pkg::STATUS_ERR : u8enc_pkg::STATUS_OK;
        end
    end

    assign o_empty      = !r_val;
    assign o_out_byte   = r_byte;
    assign o_byte_count = r_count;
    assign o_is_last    = r_last;
    assign o_status     = r_status;

endmodule
